// ===== rtl/core/tdac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdac_pkg
// Shared types, widths and constants of the throttle deadband block.
// ----------------------------------------------------------------------------
package tdac_pkg;

  localparam int SAMPLE_WIDTH = 12;
  localparam int BUTTON_COUNT = 5;
  localparam int FRAC_BITS    = 8;

  localparam int FULL_Q       = 100 << FRAC_BITS;
  localparam int FULL_Q_W     = $clog2(FULL_Q + 1);
  localparam int THR_W        = 16;
  localparam int NUM_W        = SAMPLE_WIDTH + FULL_Q_W;
  localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

  localparam int ACT_W        = 15;
  localparam int IDLE_W       = 26;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 26;

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {SAMPLE_WIDTH{1'b1}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MID = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 1));
  localparam logic [IDLE_W-1:0]       IDLE_MAX   = {IDLE_W{1'b1}};

  localparam logic [SAMPLE_WIDTH-1:0] RST_DB_HIGH  = SAMPLE_WIDTH'(2148);
  localparam logic [SAMPLE_WIDTH-1:0] RST_DB_LOW   = SAMPLE_WIDTH'(1948);
  localparam logic [SAMPLE_WIDTH-1:0] RST_CAL_GATE = SAMPLE_WIDTH'(50);
  localparam logic [ACT_W-1:0]        RST_ACT_THR  = ACT_W'(512);
  localparam logic [IDLE_W-1:0]       RST_TIMEOUT  = IDLE_W'(300000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DB_HIGH  = 3'd0,
    CFG_DB_LOW   = 3'd1,
    CFG_CAL_GATE = 3'd2,
    CFG_ACT_THR  = 3'd3,
    CFG_TIMEOUT  = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                    kind;
    logic [SAMPLE_WIDTH-1:0] pot_value;
    logic [BUTTON_COUNT-1:0] buttons;
  } in_item_t;

  typedef struct packed {
    logic signed [THR_W-1:0] throttle_q8;
    logic [BUTTON_COUNT-1:0] btn_latched;
    logic                    cal_updated;
    logic                    sleep_request;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic do_cal;
    logic do_mul;
    logic div_start;
    logic do_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== rtl/core/tdac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdac_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdac_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tdac_pkg::NUM_W-1:0]          dividend,
  input  logic [tdac_pkg::SAMPLE_WIDTH-1:0]   divisor,
  output logic                                done,
  output logic [tdac_pkg::NUM_W-1:0]          quotient
);

  logic [tdac_pkg::NUM_W-1:0]        quo_r, quo_nxt;
  logic [tdac_pkg::SAMPLE_WIDTH-1:0] rem_r, rem_nxt;
  logic [tdac_pkg::SAMPLE_WIDTH-1:0] den_r, den_nxt;
  logic [tdac_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [tdac_pkg::SAMPLE_WIDTH:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[tdac_pkg::NUM_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = tdac_pkg::SAMPLE_WIDTH'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[tdac_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[tdac_pkg::SAMPLE_WIDTH-1:0];
        quo_nxt = {quo_r[tdac_pkg::NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tdac_pkg::DIV_CNT_W'(tdac_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/tdac_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdac_datapath
// Configuration, calibration, deadband mapping and idle tracking datapath.
// ----------------------------------------------------------------------------
module tdac_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tdac_pkg::dp_cmd_t                 cmd,
  output tdac_pkg::dp_sts_t                 sts,
  input  tdac_pkg::in_item_t                in_item,
  input  logic                              cfg_we,
  input  logic [tdac_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tdac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tdac_pkg::out_item_t               out_item
);

  localparam int SW = tdac_pkg::SAMPLE_WIDTH;
  localparam int BW = tdac_pkg::BUTTON_COUNT;
  localparam int QW = tdac_pkg::FULL_Q_W;
  localparam int TW = tdac_pkg::THR_W;
  localparam int NW = tdac_pkg::NUM_W;
  localparam int IW = tdac_pkg::IDLE_W;

  // Configuration registers.
  logic [SW-1:0]            db_high_r, db_high_nxt;
  logic [SW-1:0]            db_low_r, db_low_nxt;
  logic [SW-1:0]            cal_gate_r, cal_gate_nxt;
  logic [tdac_pkg::ACT_W-1:0] act_thr_r, act_thr_nxt;
  logic [IW-1:0]            timeout_r, timeout_nxt;

  // Architectural state.
  logic [SW-1:0]            cal_min_r, cal_min_nxt;
  logic [SW-1:0]            cal_max_r, cal_max_nxt;
  logic [BW-1:0]            held_r, held_nxt;
  logic [IW-1:0]            idle_r, idle_nxt;
  logic signed [TW-1:0]     last_thr_r, last_thr_nxt;
  logic                     sleep_r, sleep_nxt;

  // Per-transaction working registers.
  tdac_pkg::in_item_t       item_r, item_nxt;
  logic                     cal_flag_r, cal_flag_nxt;
  logic                     neg_r, neg_nxt;
  logic [SW-1:0]            diff_r, diff_nxt;
  logic [SW-1:0]            den_r, den_nxt;
  logic [NW-1:0]            prod_r, prod_nxt;
  tdac_pkg::out_item_t      out_r, out_nxt;

  logic                     gate_ok;
  logic                     min_upd;
  logic                     max_upd;
  logic [SW-1:0]            new_min;
  logic [SW-1:0]            new_max;
  logic [SW:0]              hi_p1;
  logic [SW:0]              pmax;
  logic [SW-1:0]            lo_m1;
  logic [SW-1:0]            pmin;
  logic                     is_pos;
  logic                     is_neg;

  logic                     div_done;
  logic [NW-1:0]            quotient;
  logic [QW-1:0]            q_sat;
  logic signed [TW-1:0]     thr_val;
  logic                     active;
  logic [IW-1:0]            idle_new;

  tdac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    gate_ok = (item_r.kind == tdac_pkg::KIND_SAMPLE) &&
              (item_r.pot_value > cal_gate_r) &&
              (item_r.pot_value != tdac_pkg::SAMPLE_MAX);
    min_upd = gate_ok && (item_r.pot_value < cal_min_r);
    max_upd = gate_ok && (item_r.pot_value > cal_max_r);
    new_min = min_upd ? item_r.pot_value : cal_min_r;
    new_max = max_upd ? item_r.pot_value : cal_max_r;
    hi_p1   = {1'b0, db_high_r} + 1'b1;
    pmax    = ({1'b0, new_max} < hi_p1) ? hi_p1 : {1'b0, new_max};
    lo_m1   = db_low_r - 1'b1;
    pmin    = (new_min > lo_m1) ? lo_m1 : new_min;
    is_pos  = item_r.pot_value > db_high_r;
    is_neg  = !is_pos && (item_r.pot_value < db_low_r);
  end

  always_comb begin
    q_sat    = (quotient > NW'(tdac_pkg::FULL_Q)) ? QW'(tdac_pkg::FULL_Q) : quotient[QW-1:0];
    thr_val  = neg_r ? -$signed(TW'(q_sat)) : $signed(TW'(q_sat));
    active   = (item_r.buttons != held_r) || (TW'(q_sat) > TW'(act_thr_r));
    if (item_r.kind == tdac_pkg::KIND_TICK) begin
      idle_new = (idle_r != tdac_pkg::IDLE_MAX) ? idle_r + 1'b1 : idle_r;
    end else begin
      idle_new = active ? '0 : idle_r;
    end
  end

  always_comb begin
    db_high_nxt  = db_high_r;
    db_low_nxt   = db_low_r;
    cal_gate_nxt = cal_gate_r;
    act_thr_nxt  = act_thr_r;
    timeout_nxt  = timeout_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        tdac_pkg::CFG_DB_HIGH:  db_high_nxt  = cfg_wdata[SW-1:0];
        tdac_pkg::CFG_DB_LOW:   db_low_nxt   = cfg_wdata[SW-1:0];
        tdac_pkg::CFG_CAL_GATE: cal_gate_nxt = cfg_wdata[SW-1:0];
        tdac_pkg::CFG_ACT_THR:  act_thr_nxt  = cfg_wdata[tdac_pkg::ACT_W-1:0];
        tdac_pkg::CFG_TIMEOUT:  timeout_nxt  = cfg_wdata[IW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item_nxt     = item_r;
    cal_min_nxt  = cal_min_r;
    cal_max_nxt  = cal_max_r;
    cal_flag_nxt = cal_flag_r;
    neg_nxt      = neg_r;
    diff_nxt     = diff_r;
    den_nxt      = den_r;
    prod_nxt     = prod_r;
    held_nxt     = held_r;
    idle_nxt     = idle_r;
    last_thr_nxt = last_thr_r;
    sleep_nxt    = sleep_r;
    out_nxt      = out_r;
    if (cmd.load_item) begin
      item_nxt = in_item;
    end
    if (cmd.do_cal) begin
      cal_min_nxt  = new_min;
      cal_max_nxt  = new_max;
      cal_flag_nxt = min_upd || max_upd;
      neg_nxt      = is_neg;
      if (is_pos) begin
        diff_nxt = item_r.pot_value - db_high_r;
        den_nxt  = SW'(pmax - {1'b0, db_high_r});
      end else if (is_neg) begin
        diff_nxt = db_low_r - item_r.pot_value;
        den_nxt  = db_low_r - pmin;
      end else begin
        diff_nxt = '0;
        den_nxt  = SW'(1);
      end
    end
    if (cmd.do_mul) begin
      prod_nxt = NW'(diff_r) * NW'(tdac_pkg::FULL_Q);
    end
    if (cmd.do_fin) begin
      idle_nxt  = idle_new;
      sleep_nxt = sleep_r || (idle_new > timeout_r);
      if (item_r.kind == tdac_pkg::KIND_TICK) begin
        out_nxt.throttle_q8  = last_thr_r;
        out_nxt.btn_latched  = held_r;
        out_nxt.cal_updated  = 1'b0;
      end else begin
        last_thr_nxt         = thr_val;
        held_nxt             = item_r.buttons;
        out_nxt.throttle_q8  = thr_val;
        out_nxt.btn_latched  = item_r.buttons;
        out_nxt.cal_updated  = cal_flag_r;
      end
      out_nxt.sleep_request = sleep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_high_r  <= tdac_pkg::RST_DB_HIGH;
      db_low_r   <= tdac_pkg::RST_DB_LOW;
      cal_gate_r <= tdac_pkg::RST_CAL_GATE;
      act_thr_r  <= tdac_pkg::RST_ACT_THR;
      timeout_r  <= tdac_pkg::RST_TIMEOUT;
      cal_min_r  <= tdac_pkg::SAMPLE_MID;
      cal_max_r  <= tdac_pkg::SAMPLE_MID;
      held_r     <= '0;
      idle_r     <= '0;
      last_thr_r <= '0;
      sleep_r    <= 1'b0;
    end else begin
      db_high_r  <= db_high_nxt;
      db_low_r   <= db_low_nxt;
      cal_gate_r <= cal_gate_nxt;
      act_thr_r  <= act_thr_nxt;
      timeout_r  <= timeout_nxt;
      cal_min_r  <= cal_min_nxt;
      cal_max_r  <= cal_max_nxt;
      held_r     <= held_nxt;
      idle_r     <= idle_nxt;
      last_thr_r <= last_thr_nxt;
      sleep_r    <= sleep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cal_flag_r <= cal_flag_nxt;
    neg_r      <= neg_nxt;
    diff_r     <= diff_nxt;
    den_r      <= den_nxt;
    prod_r     <= prod_nxt;
    out_r      <= out_nxt;
  end

  assign sts.is_tick  = (item_r.kind == tdac_pkg::KIND_TICK);
  assign sts.div_done = div_done;
  assign out_item     = out_r;

endmodule

// ===== rtl/core/tdac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdac_ctrl
// Sequencer for one transaction and owner of the result valid flag.
// ----------------------------------------------------------------------------
module tdac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              cfg_ready,
  output tdac_pkg::dp_cmd_t cmd,
  input  tdac_pkg::dp_sts_t sts
);

  tdac_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdac_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      tdac_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = tdac_pkg::ST_CAL;
        end
      end
      tdac_pkg::ST_CAL: begin
        cmd.do_cal = 1'b1;
        state_nxt  = sts.is_tick ? tdac_pkg::ST_FIN : tdac_pkg::ST_MUL;
      end
      tdac_pkg::ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = tdac_pkg::ST_START;
      end
      tdac_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = tdac_pkg::ST_DIV;
      end
      tdac_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = tdac_pkg::ST_FIN;
        end
      end
      tdac_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.do_fin    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tdac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tdac_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != tdac_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = (state_r == tdac_pkg::ST_IDLE);

`ifndef SYNTHESIS
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tdac_pkg::ST_FIN))
    else $error("Result valid rose without a finish step.");

  a_accept_to_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == tdac_pkg::ST_CAL))
    else $error("Accepted transaction did not enter calibration.");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == tdac_pkg::ST_DIV))
    else $error("Divider finished outside the divide state.");

  a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_fin |-> (!out_valid_r || !out_stall))
    else $error("Finish step overwrote a stalled result.");
`endif

endmodule

// ===== rtl/core/throttle_deadband_autocal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_deadband_autocal
// Deadband throttle mapping with auto-calibration and idle sleep detection.
// ----------------------------------------------------------------------------
// Input transactions carry either a potentiometer sample with button bits or
// a one millisecond tick. Every input transaction yields exactly one result
// transaction with the throttle, latched buttons, calibration flag and sleep
// request. Both channels use valid and stall; a transaction moves when valid
// is high and stall is low. Configuration registers are written over the cfg
// channel by index while the block is idle.
// A sample passes from acceptance to a valid result through calibration,
// one multiply, and a restoring divider that yields one of 27 quotient bits
// per cycle. A tick skips the multiply and the divider. One transaction is
// in flight at a time; a new one is accepted once the last has finished.
// The result sits in an output register, so a new transaction is accepted
// while the previous result is stalled; a finished result then waits until
// the register is free. Synchronous reset restores the register defaults,
// centers the calibration extremes and clears the idle count and sleep flag.
// ----------------------------------------------------------------------------
module throttle_deadband_autocal (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tdac_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tdac_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tdac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tdac_pkg::dp_cmd_t cmd;
  tdac_pkg::dp_sts_t sts;

  tdac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tdac_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_item  (out_data)
  );

endmodule

// ===== tb/throttle_deadband_autocal_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_deadband_autocal_test
// Self-checking testbench for the deadband throttle block.
// ----------------------------------------------------------------------------
// Potentiometer samples and millisecond ticks are queued by the stimulus
// process. A clocked driver presents them in bursts with random gaps, and
// the receiver stalls in patterns of its own. Every accepted input transaction
// is run through a local prediction of the calibration, deadband mapping and
// idle tracking, and each result transaction is compared field by field
// against the oldest prediction. The register set is swept through default,
// extreme, random and short-timeout settings between drained phases.
// ----------------------------------------------------------------------------
module throttle_deadband_autocal_test;
  import tdac_pkg::*;

  localparam int STUCK_LIMIT = 3000;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_COIN,
    FLOW_CHOKED,
    FLOW_PERIODIC
  } flow_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  out_item_t               out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  logic [SAMPLE_WIDTH-1:0] db_high;
  logic [SAMPLE_WIDTH-1:0] db_low;
  logic [SAMPLE_WIDTH-1:0] cal_gate;
  logic [ACT_W-1:0]        act_thr;
  logic [IDLE_W-1:0]       timeout_ms;
  logic [SAMPLE_WIDTH-1:0] cal_lo;
  logic [SAMPLE_WIDTH-1:0] cal_hi;
  logic [BUTTON_COUNT-1:0] held_btn;
  logic [IDLE_W-1:0]       idle_ms;
  logic signed [THR_W-1:0] last_thr;
  logic                    sleep_seen;

  in_item_t                knob_events[$];
  out_item_t               throttle_reports[$];
  logic [BUTTON_COUNT-1:0] gen_buttons;
  int                      items_queued;
  int                      reports_seen;
  int                      mismatch_count;
  int                      stuck_cycles;
  bit                      in_taken;
  bit                      drain_hold;
  int                      burst_left;
  int                      gap_left;
  int                      bursts_started;
  flow_mode_t              flow_mode;
  int                      flow_left;
  int                      flow_tick;

  throttle_deadband_autocal i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [THR_W-1:0] map_to_throttle(logic [SAMPLE_WIDTH-1:0] pot);
    longint p;
    longint hi;
    longint lo;
    longint cmin;
    longint cmax;
    longint span;
    longint q;
    p    = pot;
    hi   = db_high;
    lo   = db_low;
    cmin = cal_lo;
    cmax = cal_hi;
    if (p > hi) begin
      span = (cmax - hi > 1) ? cmax - hi : 1;
      q = (p - hi) * FULL_Q / span;
      if (q > FULL_Q) q = FULL_Q;
      return THR_W'(q);
    end
    if (p < lo) begin
      span = (lo - cmin > 1) ? lo - cmin : 1;
      q = (lo - p) * FULL_Q / span;
      if (q > FULL_Q) q = FULL_Q;
      return THR_W'(-q);
    end
    return '0;
  endfunction

  function automatic out_item_t advance_throttle(in_item_t ev);
    out_item_t       r;
    logic            cal_hit;
    logic            active;
    logic [THR_W-1:0] mag;
    cal_hit = 1'b0;
    if (ev.kind == KIND_TICK) begin
      if (idle_ms != IDLE_MAX) idle_ms = idle_ms + 1'b1;
    end else begin
      if (ev.pot_value > cal_gate && ev.pot_value != SAMPLE_MAX) begin
        if (ev.pot_value < cal_lo) begin
          cal_lo  = ev.pot_value;
          cal_hit = 1'b1;
        end
        if (ev.pot_value > cal_hi) begin
          cal_hi  = ev.pot_value;
          cal_hit = 1'b1;
        end
      end
      last_thr = map_to_throttle(ev.pot_value);
      active   = (ev.buttons != held_btn);
      held_btn = ev.buttons;
      mag      = (last_thr < 0) ? THR_W'(-last_thr) : THR_W'(last_thr);
      if (mag > act_thr) active = 1'b1;
      if (active) idle_ms = '0;
    end
    if (idle_ms > timeout_ms) sleep_seen = 1'b1;
    r.throttle_q8   = last_thr;
    r.btn_latched   = held_btn;
    r.cal_updated   = cal_hit;
    r.sleep_request = sleep_seen;
    return r;
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] pot_near(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return SAMPLE_WIDTH'(v);
  endfunction

  function automatic in_item_t random_knob_event(int tick_pct, int btn_pct);
    in_item_t ev;
    ev.pot_value = SAMPLE_WIDTH'($urandom);
    ev.buttons   = BUTTON_COUNT'($urandom);
    if ($urandom_range(99) < tick_pct) begin
      ev.kind = KIND_TICK;
      return ev;
    end
    ev.kind = KIND_SAMPLE;
    case ($urandom_range(9))
      4, 5:    ev.pot_value = pot_near(int'(db_high), 8);
      6:       ev.pot_value = pot_near(int'(db_low), 8);
      7:       ev.pot_value = pot_near(($urandom_range(1)) ? int'(cal_lo) : int'(cal_gate), 4);
      8:       ev.pot_value = pot_near(int'(cal_hi), 4);
      9:       ev.pot_value = ($urandom_range(1)) ? pot_near(0, 1) : pot_near(int'(SAMPLE_MAX), 1);
      default: ;
    endcase
    if ($urandom_range(99) < btn_pct) gen_buttons = BUTTON_COUNT'($urandom);
    ev.buttons = gen_buttons;
    return ev;
  endfunction

  task automatic queue_event(kind_t k, int pot, int btn);
    in_item_t ev;
    ev.kind      = k;
    ev.pot_value = SAMPLE_WIDTH'(pot);
    ev.buttons   = BUTTON_COUNT'(btn);
    knob_events.push_back(ev);
    items_queued++;
  endtask

  task automatic run_items(int count, int tick_pct, int btn_pct);
    for (int n = 0; n < count; n++) begin
      knob_events.push_back(random_knob_event(tick_pct, btn_pct));
      items_queued++;
    end
  endtask

  task automatic wait_drained();
    while (reports_seen != items_queued) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DB_HIGH:  db_high    = value[SAMPLE_WIDTH-1:0];
      CFG_DB_LOW:   db_low     = value[SAMPLE_WIDTH-1:0];
      CFG_CAL_GATE: cal_gate   = value[SAMPLE_WIDTH-1:0];
      CFG_ACT_THR:  act_thr    = value[ACT_W-1:0];
      CFG_TIMEOUT:  timeout_ms = value[IDLE_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] hi, logic [CFG_DATA_W-1:0] lo,
                            logic [CFG_DATA_W-1:0] gate, logic [CFG_DATA_W-1:0] thr,
                            logic [CFG_DATA_W-1:0] tout);
    write_reg(CFG_DB_HIGH, hi);
    write_reg(CFG_DB_LOW, lo);
    write_reg(CFG_CAL_GATE, gate);
    write_reg(CFG_ACT_THR, thr);
    write_reg(CFG_TIMEOUT, tout);
    for (int k = int'(CFG_TIMEOUT) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else begin
      in_taken = 1'b0;
      if (drain_hold && throttle_reports.size() == 0) drain_hold = 1'b0;
      if (burst_left == 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
          bursts_started++;
          if (bursts_started % 40 == 20) drain_hold = 1'b1;
        end
      end
      if (burst_left != 0 && !drain_hold && knob_events.size() != 0) begin
        in_data  <= knob_events.pop_front();
        in_valid <= 1'b1;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (flow_left == 0) begin
      flow_mode = flow_mode_t'($urandom_range(3));
      flow_left = $urandom_range(20, 300);
    end
    flow_left--;
    flow_tick++;
    case (flow_mode)
      FLOW_FREE:   out_stall <= 1'b0;
      FLOW_COIN:   out_stall <= 1'($urandom_range(1));
      FLOW_CHOKED: out_stall <= ($urandom_range(9) < 8);
      default:     out_stall <= ((flow_tick % 7) < 3);
    endcase
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        throttle_reports.push_back(advance_throttle(in_data));
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (throttle_reports.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatch_count++;
        end else begin
          want = throttle_reports.pop_front();
          if (out_data.throttle_q8 !== want.throttle_q8) begin
            $error("throttle_q8: expected %0d, got %0d", want.throttle_q8,
                   out_data.throttle_q8);
            mismatch_count++;
          end
          if (out_data.btn_latched !== want.btn_latched) begin
            $error("btn_latched: expected %0h, got %0h", want.btn_latched,
                   out_data.btn_latched);
            mismatch_count++;
          end
          if (out_data.cal_updated !== want.cal_updated) begin
            $error("cal_updated: expected %0b, got %0b", want.cal_updated,
                   out_data.cal_updated);
            mismatch_count++;
          end
          if (out_data.sleep_request !== want.sleep_request) begin
            $error("sleep_request: expected %0b, got %0b", want.sleep_request,
                   out_data.sleep_request);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    db_high        = RST_DB_HIGH;
    db_low         = RST_DB_LOW;
    cal_gate       = RST_CAL_GATE;
    act_thr        = RST_ACT_THR;
    timeout_ms     = RST_TIMEOUT;
    cal_lo         = SAMPLE_MID;
    cal_hi         = SAMPLE_MID;
    held_btn       = '0;
    idle_ms        = '0;
    last_thr       = '0;
    sleep_seen     = 1'b0;
    gen_buttons    = '0;
    items_queued   = 0;
    reports_seen   = 0;
    mismatch_count = 0;
    stuck_cycles   = 0;
    in_taken       = 1'b0;
    drain_hold     = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    bursts_started = 0;
    flow_left      = 0;
    flow_tick      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_event(KIND_SAMPLE, 2048, 0);
    queue_event(KIND_SAMPLE, 4095, 31);
    queue_event(KIND_SAMPLE, 0, 31);
    queue_event(KIND_SAMPLE, 50, 0);
    queue_event(KIND_SAMPLE, 51, 0);
    queue_event(KIND_SAMPLE, 4094, 0);
    queue_event(KIND_SAMPLE, 3000, 0);
    queue_event(KIND_SAMPLE, 1000, 0);
    queue_event(KIND_SAMPLE, 2148, 0);
    queue_event(KIND_SAMPLE, 2149, 0);
    queue_event(KIND_SAMPLE, 1948, 0);
    queue_event(KIND_SAMPLE, 1947, 0);
    queue_event(KIND_TICK, 0, 0);
    queue_event(KIND_TICK, 4095, 31);
    for (int b = 0; b < BUTTON_COUNT; b++)
      queue_event(KIND_SAMPLE, 2048, 1 << b);
    queue_event(KIND_SAMPLE, 2048, 16);
    queue_event(KIND_SAMPLE, 2200, 16);
    wait_drained();

    run_items(300, 20, 15);
    wait_drained();

    set_config(26'd0, 26'd4095, 26'd0, 26'd0, CFG_DATA_W'(IDLE_MAX));
    run_items(200, 10, 30);
    wait_drained();

    set_config(26'd4094, 26'd1, 26'd4095, 26'd25600, 26'd300000);
    run_items(200, 20, 10);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      run_items(150, 25, 20);
      wait_drained();
    end

    set_config(26'd2200, 26'd1900, 26'd100, 26'd25600, 26'd60);
    run_items(250, 45, 3);
    wait_drained();

    set_config(26'd2048, 26'd2048, 26'd50, 26'd0, 26'd0);
    run_items(150, 20, 20);
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && throttle_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
